// ----- rtl/core/rgb_led_pkg.sv -----
// shared types, constants and channel arithmetic for the rgb led bit encoder
package rgb_led_pkg;

  // default store depth and reset values
  localparam int unsigned MAX_LEDS_DEF = 16;
  localparam logic [4:0]  LED_COUNT_RST = 5'd16;
  localparam logic [7:0]  LEVEL_RST = 8'hff;
  localparam logic [23:0] COLOUR_RST = 24'h000000;

  // three-bit line codes for one data bit
  localparam logic [2:0] CODE_ONE = 3'b110;
  localparam logic [2:0] CODE_ZERO = 3'b100;

  // request opcodes
  typedef enum logic [1:0] {
    OP_SET_COLOUR = 2'd0,
    OP_SET_LEVEL  = 2'd1,
    OP_SET_ALL    = 2'd2,
    OP_SHOW       = 2'd3
  } opcode_e;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FILL,
    ST_READ,
    ST_EMIT
  } state_e;

  // floor(c*b/255), exact for every 16-bit product of two bytes
  function automatic logic [7:0] scale_div255(input logic [7:0] c, input logic [7:0] b);
    logic [15:0] prod;
    logic [16:0] sum;
    prod = 16'(c) * 16'(b);
    sum = {1'b0, prod} + 17'(prod[15:8]) + 17'd1;
    return sum[15:8];
  endfunction

  // each bit msb first becomes 110 for one or 100 for zero
  function automatic logic [23:0] encode_byte(input logic [7:0] v);
    logic [23:0] word;
    word = '0;
    for (int k = 0; k < 8; k++) begin
      word[3*k +: 3] = v[k] ? CODE_ONE : CODE_ZERO;
    end
    return word;
  endfunction

endpackage

// ----- rtl/core/rgb_led_spi_bit_encoder.sv -----
// rgb led strip encoder: colour and brightness stores, show sequencer, line encoding
// set colour and set brightness are done in the idle state; set all then walks a fill state over
// every led in use. show: each led passes a read state then an emit state, a stalled result
// holds the walk; the single read port of the stores and their registered read set this pacing
// reset: led count 16; entries never written read as black and full brightness through
// per-entry valid bits, so no clearing pass is needed and requests are taken right away
module rgb_led_spi_bit_encoder #(
  parameter int unsigned MAX_LEDS = rgb_led_pkg::MAX_LEDS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [4:0]  cfg_led_count_i,
  // request channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  opcode_i,
  input  logic [7:0]  pixel_i,
  input  logic [23:0] colour_i,
  input  logic [7:0]  level_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  led_index_o,
  output logic [23:0] green_code_o,
  output logic [23:0] red_code_o,
  output logic [23:0] blue_code_o,
  output logic        last_o
);

  localparam int unsigned IdxW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
  localparam int unsigned CntW = ($clog2(MAX_LEDS + 1) > 5) ? $clog2(MAX_LEDS + 1) : 5;
  localparam int unsigned CmpW = (CntW > 8) ? CntW : 8;

  rgb_led_pkg::state_e state_q, state_d;

  logic [4:0]      led_count_q;
  logic [CntW-1:0] n_eff;
  logic [CntW-1:0] idx_q, idx_d, idx_nxt;
  logic [23:0]     fill_colour_q, fill_colour_d;

  logic            in_acc;
  logic            pixel_ok;
  logic            last_run;
  logic            out_load;
  logic            col_we, lvl_we;
  logic [IdxW-1:0] col_waddr;
  logic [23:0]     col_wdata;
  logic [IdxW-1:0] rd_addr;

  logic [23:0]     col_mem [MAX_LEDS];
  logic [7:0]      lvl_mem [MAX_LEDS];
  logic [MAX_LEDS-1:0] col_vld_q, lvl_vld_q;
  logic [23:0]     col_rd_q;
  logic [7:0]      lvl_rd_q;
  logic            col_ok_q, lvl_ok_q;

  logic [23:0]     cur_colour;
  logic [7:0]      cur_level;
  logic [CntW+3:0] idx_ext;

  logic            out_valid_q;
  logic [3:0]      led_index_q;
  logic [23:0]     green_q, red_q, blue_q;
  logic            last_q;

  // led count in effect
  always_comb begin
    n_eff = (CntW'(led_count_q) < CntW'(MAX_LEDS)) ? CntW'(led_count_q) : CntW'(MAX_LEDS);
  end

  assign in_acc   = in_valid_i && (state_q == rgb_led_pkg::ST_IDLE);
  assign pixel_ok = CmpW'(pixel_i) < CmpW'(n_eff);
  assign idx_nxt  = idx_q + CntW'(1);
  assign last_run = idx_nxt == n_eff;
  assign out_load = (state_q == rgb_led_pkg::ST_EMIT) && (!out_valid_q || !out_stall_i);
  assign rd_addr  = idx_q[IdxW-1:0];

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rgb_led_pkg::ST_IDLE: begin
        if (in_acc && n_eff != '0) begin
          if (opcode_i == rgb_led_pkg::OP_SET_ALL) begin
            state_d = rgb_led_pkg::ST_FILL;
          end else if (opcode_i == rgb_led_pkg::OP_SHOW) begin
            state_d = rgb_led_pkg::ST_READ;
          end
        end
      end
      rgb_led_pkg::ST_FILL: begin
        if (last_run) begin
          state_d = rgb_led_pkg::ST_IDLE;
        end
      end
      rgb_led_pkg::ST_READ: begin
        state_d = rgb_led_pkg::ST_EMIT;
      end
      rgb_led_pkg::ST_EMIT: begin
        if (out_load) begin
          state_d = last_run ? rgb_led_pkg::ST_IDLE : rgb_led_pkg::ST_READ;
        end
      end
      default: begin
        state_d = rgb_led_pkg::ST_IDLE;
      end
    endcase
  end

  // sequencer outputs: handshake, store writes, counter
  always_comb begin
    in_stall_o    = 1'b1;
    col_we        = 1'b0;
    lvl_we        = 1'b0;
    col_waddr     = pixel_i[IdxW-1:0];
    col_wdata     = colour_i;
    idx_d         = idx_q;
    fill_colour_d = fill_colour_q;
    case (state_q)
      rgb_led_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_acc) begin
          case (opcode_i)
            rgb_led_pkg::OP_SET_COLOUR: col_we = pixel_ok;
            rgb_led_pkg::OP_SET_LEVEL:  lvl_we = pixel_ok;
            rgb_led_pkg::OP_SET_ALL: begin
              idx_d         = '0;
              fill_colour_d = colour_i;
            end
            rgb_led_pkg::OP_SHOW: idx_d = '0;
            default: idx_d = idx_q;
          endcase
        end
      end
      rgb_led_pkg::ST_FILL: begin
        col_we    = 1'b1;
        col_waddr = idx_q[IdxW-1:0];
        col_wdata = fill_colour_q;
        idx_d     = idx_nxt;
      end
      rgb_led_pkg::ST_EMIT: begin
        if (out_load) begin
          idx_d = idx_nxt;
        end
      end
      default: begin
        idx_d = idx_q;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rgb_led_pkg::ST_IDLE;
      idx_q       <= '0;
      led_count_q <= rgb_led_pkg::LED_COUNT_RST;
      col_vld_q   <= '0;
      lvl_vld_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      if (cfg_valid_i && cfg_ready_o) begin
        led_count_q <= cfg_led_count_i;
      end
      if (col_we) begin
        col_vld_q[col_waddr] <= 1'b1;
      end
      if (lvl_we) begin
        lvl_vld_q[pixel_i[IdxW-1:0]] <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign cfg_ready_o = 1'b1;

  // colour store, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (col_we) begin
      col_mem[col_waddr] <= col_wdata;
    end
    col_rd_q <= col_mem[rd_addr];
  end

  // brightness store
  always_ff @(posedge clk_i) begin
    if (lvl_we) begin
      lvl_mem[pixel_i[IdxW-1:0]] <= level_i;
    end
    lvl_rd_q <= lvl_mem[rd_addr];
  end

  // valid flags and set-all colour, sampled alongside the reads
  always_ff @(posedge clk_i) begin
    col_ok_q      <= col_vld_q[rd_addr];
    lvl_ok_q      <= lvl_vld_q[rd_addr];
    fill_colour_q <= fill_colour_d;
  end

  // entries never written read as their reset values
  assign cur_colour = col_ok_q ? col_rd_q : rgb_led_pkg::COLOUR_RST;
  assign cur_level  = lvl_ok_q ? lvl_rd_q : rgb_led_pkg::LEVEL_RST;
  assign idx_ext    = {4'b0000, idx_q};

  // scale, encode and hold the result
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      led_index_q <= idx_ext[3:0];
      green_q     <= rgb_led_pkg::encode_byte(
                       rgb_led_pkg::scale_div255(cur_colour[15:8], cur_level));
      red_q       <= rgb_led_pkg::encode_byte(
                       rgb_led_pkg::scale_div255(cur_colour[23:16], cur_level));
      blue_q      <= rgb_led_pkg::encode_byte(
                       rgb_led_pkg::scale_div255(cur_colour[7:0], cur_level));
      last_q      <= last_run;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign led_index_o  = led_index_q;
  assign green_code_o = green_q;
  assign red_code_o   = red_q;
  assign blue_code_o  = blue_q;
  assign last_o       = last_q;

  // a show with leds in use starts with a store read
  a_show_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && opcode_i == rgb_led_pkg::OP_SHOW && n_eff != '0)
      |=> state_q == rgb_led_pkg::ST_READ)
    else $error("show request did not start a store read");

  // the walk never goes past the leds in use
  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rgb_led_pkg::ST_EMIT || state_q == rgb_led_pkg::ST_FILL) |-> idx_q < n_eff)
    else $error("led walk past the count in use");

  // a full, stalled result register holds the walk
  a_emit_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rgb_led_pkg::ST_EMIT && out_valid_q && out_stall_i)
      |=> $stable(idx_q) && state_q == rgb_led_pkg::ST_EMIT)
    else $error("walk advanced while the result was stalled");

  // the final led of a show returns to idle
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && last_run) |=> state_q == rgb_led_pkg::ST_IDLE && last_o)
    else $error("show did not end on its final led");

endmodule

// ----- test/rgb_led_spi_bit_encoder_tb.sv -----
// self-checking testbench for the rgb led spi bit encoder: scoreboard of encoded led words
module rgb_led_spi_bit_encoder_tb;

  localparam int unsigned LED_SLOTS = rgb_led_pkg::MAX_LEDS_DEF;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned CYCLE_LIMIT = 500000;

  // one request and one encoded led word
  typedef struct packed {
    rgb_led_pkg::opcode_e op;
    logic [7:0]  pixel;
    logic [23:0] colour;
    logic [7:0]  level;
  } led_req_t;

  typedef struct packed {
    logic [3:0]  idx;
    logic [23:0] green;
    logic [23:0] red;
    logic [23:0] blue;
    logic        last;
  } led_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [4:0]  cfg_led_count_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  opcode_i = '0;
  logic [7:0]  pixel_i = '0;
  logic [23:0] colour_i = '0;
  logic [7:0]  level_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [3:0]  led_index_o;
  logic [23:0] green_code_o;
  logic [23:0] red_code_o;
  logic [23:0] blue_code_o;
  logic        last_o;

  // predictor state: stores and led count
  logic [23:0] colour_mem [LED_SLOTS];
  logic [7:0]  level_mem [LED_SLOTS];
  logic [4:0]  led_count_q;

  led_req_t  pending_reqs[$];
  led_word_t led_words[$];
  led_req_t  next_req;

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_requests = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left = 0;
  int unsigned cycle_count = 0;
  int unsigned error_count = 0;
  int unsigned requests_taken = 0;
  int unsigned words_checked = 0;
  int unsigned shows_taken = 0;
  int unsigned count_writes = 0;
  bit          req_taken = 1'b0;

  rgb_led_spi_bit_encoder DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_led_count_i (cfg_led_count_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .opcode_i        (opcode_i),
    .pixel_i         (pixel_i),
    .colour_i        (colour_i),
    .level_i         (level_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .led_index_o     (led_index_o),
    .green_code_o    (green_code_o),
    .red_code_o      (red_code_o),
    .blue_code_o     (blue_code_o),
    .last_o          (last_o)
  );

  // clock and reset
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // leds in use, capped at the store depth
  function automatic int unsigned leds_in_use();
    return (led_count_q < LED_SLOTS) ? led_count_q : LED_SLOTS;
  endfunction

  // brightness scaling with exact integer floor
  function automatic logic [7:0] dim_channel(input logic [7:0] c, input logic [7:0] b);
    int unsigned prod;
    prod = 32'(c) * 32'(b);
    return 8'(prod / 255);
  endfunction

  // three line bits per data bit, msb first
  function automatic logic [23:0] line_code(input logic [7:0] v);
    logic [23:0] word;
    word = '0;
    for (int k = 7; k >= 0; k--) begin
      word = {word[20:0], (v[k] ? rgb_led_pkg::CODE_ONE : rgb_led_pkg::CODE_ZERO)};
    end
    return word;
  endfunction

  // apply one accepted request to the stores, queue the led words of a show
  task automatic apply_request(input rgb_led_pkg::opcode_e op, input logic [7:0] pixel,
                               input logic [23:0] colour, input logic [7:0] level);
    int unsigned n;
    led_word_t w;
    n = leds_in_use();
    case (op)
      rgb_led_pkg::OP_SET_COLOUR: begin
        if (pixel < n) colour_mem[pixel] = colour;
      end
      rgb_led_pkg::OP_SET_LEVEL: begin
        if (pixel < n) level_mem[pixel] = level;
      end
      rgb_led_pkg::OP_SET_ALL: begin
        for (int i = 0; i < n; i++) colour_mem[i] = colour;
      end
      default: begin
        shows_taken++;
        for (int i = 0; i < n; i++) begin
          w.idx = 4'(i);
          w.green = line_code(dim_channel(colour_mem[i][15:8], level_mem[i]));
          w.red = line_code(dim_channel(colour_mem[i][23:16], level_mem[i]));
          w.blue = line_code(dim_channel(colour_mem[i][7:0], level_mem[i]));
          w.last = (i + 1 == n);
          led_words.push_back(w);
        end
      end
    endcase
  endtask

  // request driver: launches the next pending request once the current one is taken
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || req_taken)) begin
      req_taken = 1'b0;
      if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_req = pending_reqs.pop_front();
        in_valid_i <= 1'b1;
        opcode_i <= next_req.op;
        pixel_i <= next_req.pixel;
        colour_i <= next_req.colour;
        level_i <= next_req.level;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // request acceptance feeds the predictor
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      apply_request(rgb_led_pkg::opcode_e'(opcode_i), pixel_i, colour_i, level_i);
      req_taken = 1'b1;
      requests_taken++;
    end
  end

  // result stall: random, or a long hold when one is asked for
  always @(negedge clk_i) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    led_word_t got;
    led_word_t exp_w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{led_index_o, green_code_o, red_code_o, blue_code_o, last_o};
      if (led_words.size() == 0) begin
        error_count++;
        $display("%0t: unexpected led word: led %0d g %h r %h b %h last %b", $time,
                 got.idx, got.green, got.red, got.blue, got.last);
      end else begin
        exp_w = led_words.pop_front();
        words_checked++;
        if (got !== exp_w) begin
          error_count++;
          $display("%0t: mismatch: expected led %0d g %h r %h b %h last %b", $time,
                   exp_w.idx, exp_w.green, exp_w.red, exp_w.blue, exp_w.last);
          $display("%0t:           actual   led %0d g %h r %h b %h last %b", $time,
                   got.idx, got.green, got.red, got.blue, got.last);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic queue_req(input rgb_led_pkg::opcode_e op, input logic [7:0] pixel,
                           input logic [23:0] colour, input logic [7:0] level);
    pending_reqs.push_back('{op, pixel, colour, level});
  endtask

  // channel value biased toward the extremes
  function automatic logic [7:0] pick_channel();
    int unsigned sel;
    sel = $urandom_range(5);
    if (sel == 0) return 8'h00;
    if (sel == 1) return 8'hff;
    return 8'($urandom);
  endfunction

  function automatic logic [7:0] pick_level();
    int unsigned sel;
    sel = $urandom_range(7);
    if (sel == 0) return 8'h00;
    if (sel == 1) return 8'hff;
    if (sel == 2) return 8'h01;
    return 8'($urandom);
  endfunction

  // random requests: mostly in-range writes, some wild indexes
  task automatic queue_random(input int unsigned num);
    int unsigned sel;
    int unsigned n;
    rgb_led_pkg::opcode_e op;
    logic [7:0] pixel;
    logic [23:0] colour;
    n = leds_in_use();
    for (int j = 0; j < num; j++) begin
      sel = $urandom_range(99);
      if (sel < 35) op = rgb_led_pkg::OP_SET_COLOUR;
      else if (sel < 60) op = rgb_led_pkg::OP_SET_LEVEL;
      else if (sel < 70) op = rgb_led_pkg::OP_SET_ALL;
      else op = rgb_led_pkg::OP_SHOW;
      if (n > 0 && $urandom_range(3) != 0) pixel = 8'($urandom_range(n - 1));
      else pixel = 8'($urandom_range(255));
      if ($urandom_range(1) == 0) colour = 24'($urandom);
      else colour = {pick_channel(), pick_channel(), pick_channel()};
      queue_req(op, pixel, colour, pick_level());
    end
  endtask

  // wait until every request is taken and every led word has come back
  task automatic wait_drained();
    @(posedge clk_i);
    while (pending_reqs.size() != 0 || in_valid_i || led_words.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // led count write, only with the block idle
  task automatic write_count(input logic [4:0] value);
    wait_drained();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_led_count_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    led_count_q = value;
    count_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // stimulus
  initial begin
    for (int i = 0; i < LED_SLOTS; i++) begin
      colour_mem[i] = rgb_led_pkg::COLOUR_RST;
      level_mem[i] = rgb_led_pkg::LEVEL_RST;
    end
    led_count_q = rgb_led_pkg::LED_COUNT_RST;
    wait (rst_ni);

    // reset count, no idling: directed corners
    send_idle_pct = 0;
    stall_pct = 0;
    queue_req(rgb_led_pkg::OP_SHOW, 8'h00, 24'h000000, 8'h00);
    queue_req(rgb_led_pkg::OP_SET_COLOUR, 8'd0, 24'hffffff, 8'h3c);
    queue_req(rgb_led_pkg::OP_SET_COLOUR, 8'd15, 24'h123456, 8'hff);
    queue_req(rgb_led_pkg::OP_SET_COLOUR, 8'd16, 24'hffffff, 8'h00);
    queue_req(rgb_led_pkg::OP_SET_COLOUR, 8'd255, 24'hffffff, 8'h00);
    queue_req(rgb_led_pkg::OP_SET_LEVEL, 8'd0, 24'hffffff, 8'h00);
    queue_req(rgb_led_pkg::OP_SET_LEVEL, 8'd15, 24'h000000, 8'hff);
    queue_req(rgb_led_pkg::OP_SET_LEVEL, 8'd1, 24'h5a5a5a, 8'h80);
    queue_req(rgb_led_pkg::OP_SET_LEVEL, 8'd16, 24'h000000, 8'h00);
    queue_req(rgb_led_pkg::OP_SET_LEVEL, 8'd255, 24'h000000, 8'h07);
    queue_req(rgb_led_pkg::OP_SHOW, 8'hff, 24'hffffff, 8'hff);
    queue_req(rgb_led_pkg::OP_SET_ALL, 8'hff, 24'ha5c35a, 8'h00);
    queue_req(rgb_led_pkg::OP_SHOW, 8'h00, 24'h000000, 8'h00);
    queue_req(rgb_led_pkg::OP_SET_COLOUR, 8'd1, 24'hff00ff, 8'h00);
    queue_req(rgb_led_pkg::OP_SET_COLOUR, 8'd2, 24'h00ff00, 8'hff);
    queue_req(rgb_led_pkg::OP_SET_LEVEL, 8'd2, 24'hffffff, 8'h01);
    queue_req(rgb_led_pkg::OP_SET_LEVEL, 8'd3, 24'h000000, 8'hfe);
    queue_req(rgb_led_pkg::OP_SET_COLOUR, 8'd3, 24'hffffff, 8'h00);
    queue_req(rgb_led_pkg::OP_SHOW, 8'h00, 24'h000000, 8'h00);
    queue_random(50);

    // five leds, sender mostly idle
    write_count(5'd5);
    send_idle_pct = 76;
    stall_pct = 0;
    queue_req(rgb_led_pkg::OP_SET_COLOUR, 8'd4, 24'h0000ff, 8'h00);
    queue_req(rgb_led_pkg::OP_SET_COLOUR, 8'd5, 24'hff0000, 8'h00);
    queue_req(rgb_led_pkg::OP_SET_ALL, 8'h00, 24'h00ff00, 8'h00);
    queue_req(rgb_led_pkg::OP_SHOW, 8'h00, 24'h000000, 8'h00);
    queue_random(50);

    // no leds in use, receiver mostly stalling
    write_count(5'd0);
    send_idle_pct = 0;
    stall_pct = 76;
    queue_req(rgb_led_pkg::OP_SHOW, 8'h00, 24'h000000, 8'h00);
    queue_req(rgb_led_pkg::OP_SET_COLOUR, 8'd0, 24'h000000, 8'h00);
    queue_req(rgb_led_pkg::OP_SET_LEVEL, 8'd0, 24'h000000, 8'h00);
    queue_req(rgb_led_pkg::OP_SET_ALL, 8'h00, 24'hffffff, 8'h00);
    queue_req(rgb_led_pkg::OP_SHOW, 8'h00, 24'h000000, 8'h00);
    queue_random(12);

    // count above the store, both sides idling, one long receiver hold
    write_count(5'd31);
    send_idle_pct = 10;
    stall_pct = 10;
    hold_requests++;
    queue_req(rgb_led_pkg::OP_SHOW, 8'h00, 24'h000000, 8'h00);
    queue_req(rgb_led_pkg::OP_SET_COLOUR, 8'd20, 24'hffffff, 8'h00);
    queue_req(rgb_led_pkg::OP_SET_LEVEL, 8'd30, 24'h000000, 8'h00);
    queue_req(rgb_led_pkg::OP_SHOW, 8'h00, 24'h000000, 8'h00);
    queue_random(50);

    // single led, receiver mostly stalling
    write_count(5'd1);
    send_idle_pct = 0;
    stall_pct = 76;
    queue_req(rgb_led_pkg::OP_SET_COLOUR, 8'd1, 24'hffffff, 8'h00);
    queue_req(rgb_led_pkg::OP_SHOW, 8'h00, 24'h000000, 8'h00);
    queue_random(30);

    // full strip again, both sides idling
    write_count(5'd16);
    send_idle_pct = 10;
    stall_pct = 10;
    queue_random(50);

    wait_drained();
    $display("covered %0d requests (%0d shows), %0d led words checked, %0d count writes",
             requests_taken, shows_taken, words_checked, count_writes);
    $display("led counts 16, 5, 0, 31, 1 and 16 under four idling mixes and one long hold");
    if (error_count == 0 && led_words.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
